// ===== design/itp_pkg.sv =====
// ----------------------------------------------------------------------------
// itp_pkg: shared types and constants for the integer text parser
// Register indexes, character codes, configuration and result bundles.
// ----------------------------------------------------------------------------
package itp_pkg;

	localparam int CNT_W   = 12;
	localparam int VAL_W   = 64;
	localparam int BASE_W  = 6;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [0:0] REG_NUMBER_BASE = 1'b0;
	localparam logic [0:0] REG_SIGNED_MODE = 1'b1;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_UX    = 8'h58;

	localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
	localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
	localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
	localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;
	localparam logic [BASE_W-1:0] LETTER_OFS = 6'd10;

	typedef enum logic [2:0] {
		PH_WS1,
		PH_WS2,
		PH_PLUS,
		PH_PREFIX,
		PH_ZERO,
		PH_DIGITS
	} phase_t;

	typedef struct packed {
		logic [BASE_W-1:0] number_base;
		logic              signed_mode;
	} cfg_t;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [CNT_W-1:0] end_offset;
		logic             negative;
	} result_t;

endpackage

// ===== design/integer_text_parser.sv =====
// ----------------------------------------------------------------------------
// integer_text_parser: streaming integer parser
// Parses an integer from a byte stream, one byte per beat, and emits the
// value, the consumed length and the sign at the first unaccepted byte.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------
//   in      | input     | in_valid/in_stall  | ch
//   out     | output    | out_valid/out_stall| value, end_offset, negative
//   cfg     | input     | APB psel/penable   | number_base, signed_mode
//
// One byte per cycle sustained unless out_stall holds a result; the
// terminating byte passes the byte register before its result is registered.
// The byte register feeds the parse step, whose 64-bit multiply-add by the
// base closes the state loop. Reset clears the parse state and valid flags.
// A held result with out_stall high holds a loaded byte register and stalls in.
// ----------------------------------------------------------------------------
module integer_text_parser #(
	parameter int MAX_LEN = 4095
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  ch,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [itp_pkg::VAL_W-1:0]   value,
	output logic [itp_pkg::CNT_W-1:0]   end_offset,
	output logic                        negative,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [itp_pkg::PADDR_W-1:0] paddr,
	input  logic [itp_pkg::PDATA_W-1:0] pwdata,
	output logic [itp_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);
	import itp_pkg::*;

	localparam int CNT_LIMIT = (MAX_LEN < 4095) ? MAX_LEN : 4095;

	cfg_t       cfg;
	result_t    res;
	logic       emit, advance, step;
	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       out_valid_q;
	result_t    res_q;

	itp_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	itp_parse_core #(
		.CNT_LIMIT (CNT_LIMIT)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.ch     (ch_s1),
		.cfg    (cfg),
		.emit   (emit),
		.result (res)
	);

	assign advance  = !(out_valid_q && out_stall);
	assign step     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			ch_s1 <= ch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			res_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign value      = res_q.value;
	assign end_offset = res_q.end_offset;
	assign negative   = res_q.negative;

endmodule

// ===== design/itp_apb_regs.sv =====
// ----------------------------------------------------------------------------
// itp_apb_regs: configuration registers
// APB-style register file holding the number base and the signed mode.
// ----------------------------------------------------------------------------
module itp_apb_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [itp_pkg::PADDR_W-1:0] paddr,
	input  logic [itp_pkg::PDATA_W-1:0] pwdata,
	output logic [itp_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	output itp_pkg::cfg_t               cfg
);
	import itp_pkg::*;

	logic [BASE_W-1:0] number_base_q;
	logic              signed_mode_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_base_q <= '0;
			signed_mode_q <= 1'b0;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_NUMBER_BASE: number_base_q <= pwdata[BASE_W-1:0];
				REG_SIGNED_MODE: signed_mode_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_NUMBER_BASE: prdata = {{(PDATA_W-BASE_W){1'b0}}, number_base_q};
			REG_SIGNED_MODE: prdata = {{(PDATA_W-1){1'b0}}, signed_mode_q};
			default: prdata = '0;
		endcase
	end

	assign cfg.number_base = number_base_q;
	assign cfg.signed_mode = signed_mode_q;

endmodule

// ===== design/itp_parse_core.sv =====
// ----------------------------------------------------------------------------
// itp_parse_core: per-byte parse step
// Holds the parse state and advances it by one byte per enabled cycle.
// ----------------------------------------------------------------------------
module itp_parse_core #(
	parameter int CNT_LIMIT = 4095
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       ch,
	input  itp_pkg::cfg_t    cfg,
	output logic             emit,
	output itp_pkg::result_t result
);
	import itp_pkg::*;

	localparam logic [CNT_W-1:0] LIMIT = CNT_W'(CNT_LIMIT);

	phase_t            phase_q, nxt_phase, p;
	logic [VAL_W-1:0]  acc_q, nxt_acc;
	logic [BASE_W-1:0] base_q, nxt_base;
	logic              minus_q, nxt_minus;
	logic [CNT_W-1:0]  cnt_q, nxt_cnt;
	logic              take, done, is_sp, dig_ok;
	logic [BASE_W-1:0] dig;

	always_comb begin
		is_sp  = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
		dig_ok = 1'b1;
		dig    = '0;
		if ((ch >= CH_ZERO) && (ch <= CH_NINE)) begin
			dig = BASE_W'(ch - CH_ZERO);
		end else if ((ch >= CH_LA) && (ch <= CH_LZ)) begin
			dig = BASE_W'(ch - CH_LA) + LETTER_OFS;
		end else if ((ch >= CH_UA) && (ch <= CH_UZ)) begin
			dig = BASE_W'(ch - CH_UA) + LETTER_OFS;
		end else begin
			dig_ok = 1'b0;
		end
	end

	always_comb begin
		nxt_phase = phase_q;
		nxt_acc   = acc_q;
		nxt_base  = base_q;
		nxt_minus = minus_q;
		take      = 1'b0;
		emit      = 1'b0;
		done      = 1'b0;
		p         = phase_q;

		if (p == PH_WS1) begin
			if (is_sp) begin
				take = 1'b1;
				done = 1'b1;
			end else if ((ch == CH_MINUS) && cfg.signed_mode) begin
				nxt_minus = 1'b1;
				take      = 1'b1;
				nxt_phase = PH_WS2;
				done      = 1'b1;
			end else begin
				p = PH_PLUS;
			end
		end else if (p == PH_WS2) begin
			if (is_sp) begin
				take = 1'b1;
				done = 1'b1;
			end else begin
				p = PH_PLUS;
			end
		end

		if (!done && (p == PH_PLUS)) begin
			if (ch == CH_PLUS) begin
				take      = 1'b1;
				nxt_phase = PH_PREFIX;
				done      = 1'b1;
			end else begin
				p = PH_PREFIX;
			end
		end

		if (!done && (p == PH_PREFIX)) begin
			if ((ch == CH_ZERO) &&
			    ((cfg.number_base == BASE_AUTO) || (cfg.number_base == BASE_HEX))) begin
				take      = 1'b1;
				nxt_acc   = '0;
				nxt_base  = (cfg.number_base == BASE_HEX) ? BASE_HEX : BASE_OCT;
				nxt_phase = PH_ZERO;
				done      = 1'b1;
			end else begin
				nxt_base = (cfg.number_base == BASE_AUTO) ? BASE_DEC : cfg.number_base;
				p        = PH_DIGITS;
			end
		end

		if (!done && (p == PH_ZERO)) begin
			if ((ch == CH_LX) || (ch == CH_UX)) begin
				take      = 1'b1;
				nxt_base  = BASE_HEX;
				nxt_phase = PH_DIGITS;
				done      = 1'b1;
			end else begin
				p = PH_DIGITS;
			end
		end

		if (!done) begin
			if ((p == PH_DIGITS) && dig_ok && (dig < nxt_base)) begin
				nxt_acc   = acc_q * VAL_W'(nxt_base) + VAL_W'(dig);
				take      = 1'b1;
				nxt_phase = PH_DIGITS;
			end else begin
				emit = 1'b1;
			end
		end

		nxt_cnt = (take && (cnt_q < LIMIT)) ? cnt_q + 1'b1 : cnt_q;

		if (emit) begin
			nxt_phase = PH_WS1;
			nxt_acc   = '0;
			nxt_base  = '0;
			nxt_minus = 1'b0;
			nxt_cnt   = '0;
		end
	end

	assign result.value      = minus_q ? (VAL_W'(0) - acc_q) : acc_q;
	assign result.end_offset = cnt_q;
	assign result.negative   = minus_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WS1;
			acc_q   <= '0;
			base_q  <= '0;
			minus_q <= 1'b0;
			cnt_q   <= '0;
		end else if (step) begin
			phase_q <= nxt_phase;
			acc_q   <= nxt_acc;
			base_q  <= nxt_base;
			minus_q <= nxt_minus;
			cnt_q   <= nxt_cnt;
		end
	end

endmodule
